// File: rtl/vns_pkg.sv
`default_nettype none
package vns_pkg;

  localparam int MAX_EXTENT = 32;
  localparam int COORD_LIMIT = 32;
  localparam int EXT_CAP = (MAX_EXTENT < COORD_LIMIT) ? MAX_EXTENT : COORD_LIMIT;
  localparam int COORD_W = 5;
  localparam int EXT_W = 6;
  localparam int ADDR_W = 15;
  localparam int DATA_W = 16;
  localparam int ARITH_W = 64;
  localparam int DIVB_W = 10;
  localparam int CNT_W = 7;

  localparam logic MODE_DIV = 1'b0;
  localparam logic MODE_SQRT = 1'b1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] REG_SIZE_X = 2'd0;
  localparam logic [1:0] REG_SIZE_Y = 2'd1;
  localparam logic [1:0] REG_SIZE_Z = 2'd2;

  typedef struct packed {
    logic start;
    logic mode;
  } arith_req_t;

  function automatic logic [EXT_W-1:0] eff_extent(input logic [EXT_W-1:0] r);
    logic [EXT_W-1:0] v;
    v = r;
    if (v == '0) v = EXT_W'(1);
    if (v > EXT_W'(EXT_CAP)) v = EXT_W'(EXT_CAP);
    return v;
  endfunction

endpackage
`default_nettype wire

// File: rtl/voxel_neighborhood_stats_top.sv
`default_nettype none
// load or out-of-range item: result strobe from S_OUT, which follows S_CHK after the accepting edge
// query: result strobe after n window reads (n = window size up to 27), six gradient reads
// on the single store read port, then the bit-serial divide and square root unit
// throughput: one item at a time, next start taken the cycle after the strobe
// reset: synchronous active-low, clears control and extents to 32, store contents undefined
module voxel_neighborhood_stats_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        in_operation,
  input  wire logic [vns_pkg::COORD_W-1:0] in_coord_x,
  input  wire logic [vns_pkg::COORD_W-1:0] in_coord_y,
  input  wire logic [vns_pkg::COORD_W-1:0] in_coord_z,
  input  wire logic [vns_pkg::DATA_W-1:0]  in_sample,
  output logic                             out_valid,
  output logic                             out_status,
  output logic      [vns_pkg::ADDR_W-1:0]  out_linear_index,
  output logic      [vns_pkg::DATA_W-1:0]  out_intensity,
  output logic      [23:0]                 out_mean_q8,
  output logic      [23:0]                 out_stddev_q8,
  output logic      [23:0]                 out_gradient_q8,
  input  wire logic                        cfg_we,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [vns_pkg::EXT_W-1:0]   cfg_data
);
  import vns_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHK   = 4'd1;
  localparam logic [3:0] S_CEN   = 4'd2;
  localparam logic [3:0] S_WRD   = 4'd3;
  localparam logic [3:0] S_WACC  = 4'd4;
  localparam logic [3:0] S_GRD   = 4'd5;
  localparam logic [3:0] S_GACC  = 4'd6;
  localparam logic [3:0] S_MEAN  = 4'd7;
  localparam logic [3:0] S_MEANW = 4'd8;
  localparam logic [3:0] S_VAR   = 4'd9;
  localparam logic [3:0] S_VDIV  = 4'd10;
  localparam logic [3:0] S_VDIVW = 4'd11;
  localparam logic [3:0] S_SDW   = 4'd12;
  localparam logic [3:0] S_GRW   = 4'd13;
  localparam logic [3:0] S_OUT   = 4'd14;

  logic [3:0] state_r, state_nxt;
  logic [EXT_W-1:0] reg_sx_r, reg_sy_r, reg_sz_r;
  logic [EXT_W-1:0] sx_r, sx_nxt, sy_r, sy_nxt, sz_r, sz_nxt;
  logic [10:0] sxy_r, sxy_nxt;
  logic op_r, op_nxt;
  logic [COORD_W-1:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic [COORD_W-1:0] cx_r, cx_nxt, cy_r, cy_nxt, cz_r, cz_nxt;
  logic [DATA_W-1:0] sample_r, sample_nxt;
  logic [20:0] s1_r, s1_nxt;
  logic [36:0] s2_r, s2_nxt;
  logic [4:0] n_r, n_nxt;
  logic [34:0] d2_r, d2_nxt;
  logic [DATA_W-1:0] hi_r, hi_nxt;
  logic [2:0] g_r, g_nxt;
  logic [41:0] t1_r, t1_nxt, sq_r, sq_nxt;
  logic status_r, status_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [DATA_W-1:0] int_r, int_nxt;
  logic [23:0] mean_r, mean_nxt, sd_r, sd_nxt, gr_r, gr_nxt;

  logic [ADDR_W-1:0] addr;
  logic [DATA_W-1:0] rdata;
  logic we;
  arith_req_t areq;
  logic [ARITH_W-1:0] opa;
  logic [DIVB_W-1:0] opb;
  logic adone;
  logic [ARITH_W-1:0] ares;
  logic [COORD_W-1:0] lx, ly, lz, hx, hy, hz;
  logic [COORD_W-1:0] gx, gy, gz;
  logic [DATA_W-1:0] dabs;

  function automatic logic [COORD_W-1:0] lower_of(input logic [COORD_W-1:0] c);
    return (c > '0) ? c - COORD_W'(1) : '0;
  endfunction

  function automatic logic [COORD_W-1:0] upper_of(input logic [COORD_W-1:0] c,
                                                  input logic [EXT_W-1:0] s);
    logic [EXT_W-1:0] c1;
    c1 = {1'b0, c} + EXT_W'(1);
    return (c1 < s) ? c1[COORD_W-1:0] : COORD_W'(s - EXT_W'(1));
  endfunction

  always_comb begin
    lx = lower_of(x_r);
    ly = lower_of(y_r);
    lz = lower_of(z_r);
    hx = upper_of(x_r, sx_r);
    hy = upper_of(y_r, sy_r);
    hz = upper_of(z_r, sz_r);
  end

  // gradient neighbor order: hx lx hy ly hz lz
  always_comb begin
    gx = x_r;
    gy = y_r;
    gz = z_r;
    case (g_nxt)
      3'd0: gx = hx;
      3'd1: gx = lx;
      3'd2: gy = hy;
      3'd3: gy = ly;
      3'd4: gz = hz;
      default: gz = lz;
    endcase
  end

  assign addr = ADDR_W'(({11'd0, cz_r} * {5'd0, sxy_r}) +
                        ({11'd0, cy_r} * {10'd0, sx_r}) + {11'd0, cx_r});
  assign dabs = (hi_r > rdata) ? hi_r - rdata : rdata - hi_r;

  always_comb begin
    state_nxt = state_r;
    sx_nxt = sx_r; sy_nxt = sy_r; sz_nxt = sz_r; sxy_nxt = sxy_r;
    op_nxt = op_r; x_nxt = x_r; y_nxt = y_r; z_nxt = z_r;
    cx_nxt = cx_r; cy_nxt = cy_r; cz_nxt = cz_r;
    sample_nxt = sample_r;
    s1_nxt = s1_r; s2_nxt = s2_r; n_nxt = n_r; d2_nxt = d2_r;
    hi_nxt = hi_r; g_nxt = g_r; t1_nxt = t1_r; sq_nxt = sq_r;
    status_nxt = status_r; idx_nxt = idx_r; int_nxt = int_r;
    mean_nxt = mean_r; sd_nxt = sd_r; gr_nxt = gr_r;
    we = 1'b0;
    areq = '{start: 1'b0, mode: MODE_DIV};
    opa = '0;
    opb = {5'd0, n_r};
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          sx_nxt = eff_extent(reg_sx_r);
          sy_nxt = eff_extent(reg_sy_r);
          sz_nxt = eff_extent(reg_sz_r);
          sxy_nxt = {5'd0, eff_extent(reg_sx_r)} * {5'd0, eff_extent(reg_sy_r)};
          op_nxt = in_operation;
          x_nxt = in_coord_x; y_nxt = in_coord_y; z_nxt = in_coord_z;
          cx_nxt = in_coord_x; cy_nxt = in_coord_y; cz_nxt = in_coord_z;
          sample_nxt = in_sample;
          status_nxt = 1'b0; idx_nxt = '0; int_nxt = '0;
          mean_nxt = '0; sd_nxt = '0; gr_nxt = '0;
          s1_nxt = '0; s2_nxt = '0; n_nxt = '0; d2_nxt = '0; g_nxt = '0;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if ({1'b0, x_r} >= sx_r || {1'b0, y_r} >= sy_r || {1'b0, z_r} >= sz_r) begin
          status_nxt = 1'b1;
          state_nxt = S_OUT;
        end else begin
          idx_nxt = addr;
          if (op_r == OP_LOAD) begin
            we = 1'b1;
            int_nxt = sample_r;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_CEN;
          end
        end
      end
      S_CEN: begin
        int_nxt = rdata;
        cx_nxt = lx; cy_nxt = ly; cz_nxt = lz;
        state_nxt = S_WRD;
      end
      S_WRD: state_nxt = S_WACC;
      S_WACC: begin
        s1_nxt = s1_r + 21'(rdata);
        s2_nxt = s2_r + {5'd0, {16'd0, rdata} * {16'd0, rdata}};
        n_nxt = n_r + 5'd1;
        state_nxt = S_WRD;
        if (cz_r < hz) begin
          cz_nxt = cz_r + COORD_W'(1);
        end else begin
          cz_nxt = lz;
          if (cy_r < hy) begin
            cy_nxt = cy_r + COORD_W'(1);
          end else begin
            cy_nxt = ly;
            if (cx_r < hx) begin
              cx_nxt = cx_r + COORD_W'(1);
            end else begin
              g_nxt = 3'd0;
              cx_nxt = gx; cy_nxt = gy; cz_nxt = gz;
              state_nxt = S_GRD;
            end
          end
        end
      end
      S_GRD: state_nxt = S_GACC;
      S_GACC: begin
        if (!g_r[0]) begin
          hi_nxt = rdata;
        end else begin
          d2_nxt = d2_r + {3'd0, {16'd0, dabs} * {16'd0, dabs}};
        end
        if (g_r == 3'd5) begin
          state_nxt = S_MEAN;
        end else begin
          g_nxt = g_r + 3'd1;
          cx_nxt = gx; cy_nxt = gy; cz_nxt = gz;
          state_nxt = S_GRD;
        end
      end
      S_MEAN: begin
        areq = '{start: 1'b1, mode: MODE_DIV};
        opa = ARITH_W'({s1_r, 8'd0});
        state_nxt = S_MEANW;
      end
      S_MEANW: begin
        if (adone) begin
          mean_nxt = ares[23:0];
          t1_nxt = {5'd0, s2_r} * {37'd0, n_r};
          sq_nxt = {21'd0, s1_r} * {21'd0, s1_r};
          state_nxt = S_VAR;
        end
      end
      S_VAR: begin
        t1_nxt = t1_r - sq_r;
        state_nxt = S_VDIV;
      end
      S_VDIV: begin
        areq = '{start: 1'b1, mode: MODE_DIV};
        opa = ARITH_W'({t1_r, 16'd0});
        opb = {5'd0, n_r} * {5'd0, n_r};
        state_nxt = S_VDIVW;
      end
      S_VDIVW: begin
        if (adone) begin
          areq = '{start: 1'b1, mode: MODE_SQRT};
          opa = ares;
          state_nxt = S_SDW;
        end
      end
      S_SDW: begin
        if (adone) begin
          sd_nxt = ares[23:0];
          areq = '{start: 1'b1, mode: MODE_SQRT};
          opa = ARITH_W'({d2_r, 14'd0});
          state_nxt = S_GRW;
        end
      end
      S_GRW: begin
        if (adone) begin
          gr_nxt = ares[23:0];
          state_nxt = S_OUT;
        end
      end
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      reg_sx_r <= EXT_W'(32);
      reg_sy_r <= EXT_W'(32);
      reg_sz_r <= EXT_W'(32);
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SIZE_X: reg_sx_r <= cfg_data;
          REG_SIZE_Y: reg_sy_r <= cfg_data;
          REG_SIZE_Z: reg_sz_r <= cfg_data;
          default: ;
        endcase
      end
    end
    sx_r <= sx_nxt; sy_r <= sy_nxt; sz_r <= sz_nxt; sxy_r <= sxy_nxt;
    op_r <= op_nxt; x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt;
    cx_r <= cx_nxt; cy_r <= cy_nxt; cz_r <= cz_nxt;
    sample_r <= sample_nxt;
    s1_r <= s1_nxt; s2_r <= s2_nxt; n_r <= n_nxt; d2_r <= d2_nxt;
    hi_r <= hi_nxt; g_r <= g_nxt; t1_r <= t1_nxt; sq_r <= sq_nxt;
    status_r <= status_nxt; idx_r <= idx_nxt; int_r <= int_nxt;
    mean_r <= mean_nxt; sd_r <= sd_nxt; gr_r <= gr_nxt;
  end

  vns_store u_store (
    .clk   (clk),
    .we    (we),
    .waddr (addr),
    .wdata (sample_r),
    .raddr (addr),
    .rdata (rdata)
  );

  vns_arith u_arith (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (areq),
    .opa    (opa),
    .opb    (opb),
    .done   (adone),
    .result (ares)
  );

  assign busy = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_status = status_r;
  assign out_linear_index = idx_r;
  assign out_intensity = int_r;
  assign out_mean_q8 = mean_r;
  assign out_stddev_q8 = sd_r;
  assign out_gradient_q8 = gr_r;

`ifndef NO_ASSERTIONS
  a_strobe_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy) else $error("busy after result strobe");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid)) else $error("request not taken");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (out_linear_index == '0 && out_intensity == '0 &&
     out_mean_q8 == '0 && out_stddev_q8 == '0 && out_gradient_q8 == '0))
    else $error("error result carries data");
`endif

endmodule
`default_nettype wire

// File: rtl/vns_store.sv
`default_nettype none
module vns_store (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [vns_pkg::ADDR_W-1:0] waddr,
  input  wire logic [vns_pkg::DATA_W-1:0] wdata,
  input  wire logic [vns_pkg::ADDR_W-1:0] raddr,
  output logic      [vns_pkg::DATA_W-1:0] rdata
);
  import vns_pkg::*;

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/vns_arith.sv
`default_nettype none
module vns_arith (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire vns_pkg::arith_req_t         req,
  input  wire logic [vns_pkg::ARITH_W-1:0] opa,
  input  wire logic [vns_pkg::DIVB_W-1:0]  opb,
  output logic                             done,
  output logic      [vns_pkg::ARITH_W-1:0] result
);
  import vns_pkg::*;

  logic               run_r, run_nxt;
  logic               mode_r, mode_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [ARITH_W-1:0] acc_r, acc_nxt;
  logic [ARITH_W-1:0] res_r, res_nxt;
  logic [ARITH_W-1:0] bit_r, bit_nxt;
  logic [DIVB_W-1:0]  rem_r, rem_nxt;
  logic [DIVB_W-1:0]  div_r, div_nxt;
  logic [DIVB_W:0]    rem_sh;
  logic [ARITH_W-1:0] trial;
  logic [CNT_W-1:0]   last;

  always_comb begin
    rem_sh = {rem_r, acc_r[ARITH_W-1]};
    trial = res_r + bit_r;
    last = (mode_r == MODE_DIV) ? CNT_W'(ARITH_W - 1) : CNT_W'(ARITH_W / 2 - 1);
    run_nxt = run_r;
    mode_nxt = mode_r;
    cnt_nxt = cnt_r;
    acc_nxt = acc_r;
    res_nxt = res_r;
    bit_nxt = bit_r;
    rem_nxt = rem_r;
    div_nxt = div_r;
    done_nxt = 1'b0;
    if (req.start) begin
      run_nxt = 1'b1;
      mode_nxt = req.mode;
      cnt_nxt = '0;
      acc_nxt = opa;
      res_nxt = '0;
      bit_nxt = ARITH_W'(1) << (ARITH_W - 2);
      rem_nxt = '0;
      div_nxt = opb;
    end else if (run_r) begin
      if (mode_r == MODE_DIV) begin
        if (rem_sh >= {1'b0, div_r}) begin
          rem_nxt = DIVB_W'(rem_sh - {1'b0, div_r});
          acc_nxt = {acc_r[ARITH_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[DIVB_W-1:0];
          acc_nxt = {acc_r[ARITH_W-2:0], 1'b0};
        end
      end else begin
        if (acc_r >= trial) begin
          acc_nxt = acc_r - trial;
          res_nxt = (res_r >> 1) + bit_r;
        end else begin
          res_nxt = res_r >> 1;
        end
        bit_nxt = bit_r >> 2;
      end
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == last) begin
        run_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r <= run_nxt;
      done_r <= done_nxt;
    end
    mode_r <= mode_nxt;
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done = done_r;
  assign result = (mode_r == MODE_DIV) ? acc_r : res_r;

endmodule
`default_nettype wire

// File: tb/sv/tb_voxel_neighborhood_stats_top.sv
`timescale 1ns / 100ps
module tb_voxel_neighborhood_stats_top;
  import vns_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic        status;
    logic [14:0] linear_index;
    logic [15:0] intensity;
    logic [23:0] mean_q8;
    logic [23:0] stddev_q8;
    logic [23:0] gradient_q8;
  } voxel_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_operation = OP_LOAD;
  logic [4:0]  in_coord_x = '0;
  logic [4:0]  in_coord_y = '0;
  logic [4:0]  in_coord_z = '0;
  logic [15:0] in_sample = '0;
  logic        out_valid;
  logic        out_status;
  logic [14:0] out_linear_index;
  logic [15:0] out_intensity;
  logic [23:0] out_mean_q8;
  logic [23:0] out_stddev_q8;
  logic [23:0] out_gradient_q8;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_SIZE_X;
  logic [5:0]  cfg_data = '0;

  voxel_result_t pending_results[$];
  logic [15:0]   voxel_mem[32768];
  bit            voxel_written[32768];
  logic [5:0]    extent_reg[3];
  int            fail_count = 0;
  int            cycle_count = 0;
  int            sender_idle_pct = 0;

  voxel_neighborhood_stats_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_coord_x(in_coord_x), .in_coord_y(in_coord_y),
    .in_coord_z(in_coord_z), .in_sample(in_sample),
    .out_valid(out_valid), .out_status(out_status), .out_linear_index(out_linear_index),
    .out_intensity(out_intensity), .out_mean_q8(out_mean_q8),
    .out_stddev_q8(out_stddev_q8), .out_gradient_q8(out_gradient_q8),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("voxel_neighborhood_stats_top regression: fail");
      $finish;
    end
  end

  function automatic int extent_of(input logic [5:0] r);
    int v;
    v = r;
    if (v == 0) v = 1;
    if (v > 32) v = 32;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic int voxel_addr(input int x, input int y, input int z);
    int sx, sy;
    sx = extent_of(extent_reg[0]);
    sy = extent_of(extent_reg[1]);
    return (z * sx * sy + y * sx + x) % 32768;
  endfunction

  function automatic int lo_nb(input int c);
    return (c > 0) ? c - 1 : 0;
  endfunction

  function automatic int hi_nb(input int c, input int s);
    return (c + 1 < s) ? c + 1 : s - 1;
  endfunction

  function automatic bit window_written(input int x, input int y, input int z);
    int sx, sy, sz;
    bit ok;
    sx = extent_of(extent_reg[0]);
    sy = extent_of(extent_reg[1]);
    sz = extent_of(extent_reg[2]);
    ok = 1'b1;
    for (int i = lo_nb(x); i <= hi_nb(x, sx); i++)
      for (int j = lo_nb(y); j <= hi_nb(y, sy); j++)
        for (int k = lo_nb(z); k <= hi_nb(z, sz); k++)
          if (!voxel_written[voxel_addr(i, j, k)]) ok = 1'b0;
    return ok;
  endfunction

  function automatic longint unsigned abs_diff(input longint unsigned a,
                                               input longint unsigned b);
    return (a > b) ? a - b : b - a;
  endfunction

  task automatic predict_stats(input logic op, input int x, input int y, input int z,
                               input logic [15:0] smp);
    voxel_result_t r;
    int sx, sy, sz, a;
    longint unsigned s1, s2, n, v, num, dx, dy, dz;
    r = '{default: '0};
    sx = extent_of(extent_reg[0]);
    sy = extent_of(extent_reg[1]);
    sz = extent_of(extent_reg[2]);
    s1 = 0;
    s2 = 0;
    n = 0;
    if (x >= sx || y >= sy || z >= sz) begin
      r.status = 1'b1;
    end else begin
      a = voxel_addr(x, y, z);
      r.linear_index = a[14:0];
      if (op == OP_LOAD) begin
        voxel_mem[a] = smp;
        voxel_written[a] = 1'b1;
        r.intensity = smp;
      end else begin
        r.intensity = voxel_mem[a];
        for (int i = lo_nb(x); i <= hi_nb(x, sx); i++)
          for (int j = lo_nb(y); j <= hi_nb(y, sy); j++)
            for (int k = lo_nb(z); k <= hi_nb(z, sz); k++) begin
              v = voxel_mem[voxel_addr(i, j, k)];
              s1 += v;
              s2 += v * v;
              n++;
            end
        r.mean_q8 = 24'((s1 << 8) / n);
        num = n * s2 - s1 * s1;
        r.stddev_q8 = 24'(int_sqrt((num << 16) / (n * n)));
        dx = abs_diff(voxel_mem[voxel_addr(hi_nb(x, sx), y, z)],
                      voxel_mem[voxel_addr(lo_nb(x), y, z)]);
        dy = abs_diff(voxel_mem[voxel_addr(x, hi_nb(y, sy), z)],
                      voxel_mem[voxel_addr(x, lo_nb(y), z)]);
        dz = abs_diff(voxel_mem[voxel_addr(x, y, hi_nb(z, sz))],
                      voxel_mem[voxel_addr(x, y, lo_nb(z))]);
        r.gradient_q8 = 24'(int_sqrt(((dx * dx + dy * dy + dz * dz) << 16) / 4));
      end
    end
    pending_results.push_back(r);
  endtask

  always @(posedge clk) begin
    voxel_result_t e;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        fail_count++;
      end else begin
        e = pending_results.pop_front();
        if (out_status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_status); fail_count++;
        end
        if (out_linear_index !== e.linear_index) begin
          $error("linear_index exp %0d got %0d", e.linear_index, out_linear_index);
          fail_count++;
        end
        if (out_intensity !== e.intensity) begin
          $error("intensity exp %0d got %0d", e.intensity, out_intensity); fail_count++;
        end
        if (out_mean_q8 !== e.mean_q8) begin
          $error("mean_q8 exp %0d got %0d", e.mean_q8, out_mean_q8); fail_count++;
        end
        if (out_stddev_q8 !== e.stddev_q8) begin
          $error("stddev_q8 exp %0d got %0d", e.stddev_q8, out_stddev_q8); fail_count++;
        end
        if (out_gradient_q8 !== e.gradient_q8) begin
          $error("gradient_q8 exp %0d got %0d", e.gradient_q8, out_gradient_q8);
          fail_count++;
        end
      end
    end
  end

  task automatic send_request(input logic op, input int x, input int y, input int z,
                              input logic [15:0] smp);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_operation <= op;
    in_coord_x <= 5'(x);
    in_coord_y <= 5'(y);
    in_coord_z <= 5'(z);
    in_sample <= smp;
    do @(posedge clk); while (busy);
    predict_stats(op, x, y, z, smp);
  endtask

  task automatic wait_all_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_extents(input logic [5:0] ex, input logic [5:0] ey,
                             input logic [5:0] ez);
    logic [5:0] vals[3];
    vals = '{ex, ey, ez};
    wait_all_results();
    for (int i = 0; i < 3; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 2'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      extent_reg[i] = vals[i];
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic fill_volume();
    int sx, sy, sz;
    sx = extent_of(extent_reg[0]);
    sy = extent_of(extent_reg[1]);
    sz = extent_of(extent_reg[2]);
    for (int k = 0; k < sz; k++)
      for (int j = 0; j < sy; j++)
        for (int i = 0; i < sx; i++)
          send_request(OP_LOAD, i, j, k, ($urandom_range(0, 3) == 0) ?
                       (($urandom_range(0, 1) == 1) ? 16'hffff : 16'h0000) :
                       16'($urandom));
  endtask

  task automatic query_all();
    for (int k = 0; k < extent_of(extent_reg[2]); k++)
      for (int j = 0; j < extent_of(extent_reg[1]); j++)
        for (int i = 0; i < extent_of(extent_reg[0]); i++)
          send_request(OP_QUERY, i, j, k, 16'($urandom));
  endtask

  task automatic test_reset_extents();
    send_request(OP_LOAD, 31, 31, 31, 16'hffff);
    send_request(OP_LOAD, 0, 0, 0, 16'h0000);
  endtask

  task automatic test_zero_extent();
    set_extents(6'd0, 6'd0, 6'd0);
    send_request(OP_LOAD, 0, 0, 0, 16'hffff);
    send_request(OP_QUERY, 0, 0, 0, 16'h0000);
    send_request(OP_LOAD, 1, 0, 0, 16'h1234);
    send_request(OP_QUERY, 0, 31, 0, 16'hffff);
    send_request(OP_QUERY, 0, 0, 31, 16'h0);
  endtask

  task automatic test_saturated_extent();
    set_extents(6'd63, 6'd63, 6'd63);
    for (int k = 30; k < 32; k++)
      for (int j = 30; j < 32; j++)
        for (int i = 30; i < 32; i++)
          send_request(OP_LOAD, i, j, k, ((i + j + k) % 2 == 1) ? 16'hffff : 16'h0000);
    send_request(OP_QUERY, 31, 31, 31, 16'h0);
  endtask

  task automatic test_clipped_edges();
    set_extents(6'd3, 6'd1, 6'd2);
    fill_volume();
    query_all();
    send_request(OP_QUERY, 3, 0, 0, 16'h0);
  endtask

  task automatic test_random_phase(input int idle_pct, input int phases);
    int r, x, y, z;
    logic op;
    logic [5:0] e[3];
    sender_idle_pct = idle_pct;
    for (int p = 0; p < phases; p++) begin
      for (int i = 0; i < 3; i++) e[i] = 6'($urandom_range(1, 4));
      if ($urandom_range(0, 3) == 0) e[$urandom_range(0, 2)] = 6'd32;
      if ($urandom_range(0, 5) == 0) e[$urandom_range(0, 2)] = 6'd0;
      set_extents(e[0], e[1], e[2]);
      if ($urandom_range(0, 1) == 1) fill_volume();
      for (int n = 0; n < 100; n++) begin
        r = $urandom_range(0, 99);
        if (n == 50 && p == 0) wait_all_results();
        if (r < 10) begin
          op = 1'($urandom);
          x = $urandom_range(0, 31);
          y = $urandom_range(0, 31);
          z = $urandom_range(0, 31);
          if (op == OP_QUERY && x < extent_of(extent_reg[0]) &&
              y < extent_of(extent_reg[1]) && z < extent_of(extent_reg[2]) &&
              !window_written(x, y, z))
            op = OP_LOAD;
          send_request(op, x, y, z, 16'($urandom));
        end else begin
          x = $urandom_range(0, extent_of(extent_reg[0]) - 1);
          y = $urandom_range(0, extent_of(extent_reg[1]) - 1);
          z = $urandom_range(0, extent_of(extent_reg[2]) - 1);
          if (r < 40 || !window_written(x, y, z))
            send_request(OP_LOAD, x, y, z, 16'($urandom));
          else
            send_request(OP_QUERY, x, y, z, 16'($urandom));
        end
      end
    end
  endtask

  initial begin
    extent_reg = '{6'd32, 6'd32, 6'd32};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_extents();
    test_zero_extent();
    test_saturated_extent();
    test_clipped_edges();
    test_random_phase(32, 4);
    test_random_phase(87, 4);
    test_random_phase(0, 4);
    wait_all_results();
    repeat (300) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0)
      $display("voxel_neighborhood_stats_top regression: pass");
    else
      $display("voxel_neighborhood_stats_top regression: fail");
    $finish;
  end

endmodule
